// ===== sv/qmu_pkg.sv =====
`timescale 1ns / 1ps

package qmu_pkg;

  // Operation select carried on the input tuser
  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_CNJ = 3'd1,
    OP_NRM = 3'd2,
    OP_ROT = 3'd3,
    OP_SCL = 3'd4,
    OP_DIV = 3'd5
  } opcode_e;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Component index: 0 x, 1 y, 2 z, 3 w
  typedef logic [1:0] idx_t;

  // Hamilton product: term k of lane l is +/- a[MUL_A[k]] * b[MUL_B[l][k]]
  localparam idx_t MUL_A [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam idx_t MUL_B [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  // Negate flags per lane, bit k for term k
  localparam logic [3:0] MUL_N [4] = '{4'b1000, 4'b0010, 4'b0100, 4'b1110};

  // Cross product: lane l = u[CRS_A[l]] * v[CRS_B[l]] - u[CRS_B[l]] * v[CRS_A[l]]
  // (fourth entry is never used)
  localparam idx_t CRS_A [4] = '{2'd1, 2'd2, 2'd0, 2'd0};
  localparam idx_t CRS_B [4] = '{2'd2, 2'd0, 2'd1, 2'd0};

endpackage

// ===== sv/qmu_pipe.sv =====
`timescale 1ns / 1ps

// Delay line with stall enable; aligns side data with the arithmetic units
module qmu_pipe #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stg_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        stg_q[i] <= stg_q[i-1];
      end
    end
  end

  assign q_o = stg_q[DEPTH-1];

endmodule

// ===== sv/qmu_lane.sv =====
`timescale 1ns / 1ps

// One lane: four signed products, then signed sum plus addend,
// round half up, saturate to the data width
module qmu_lane #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   x_i [4],
  input  logic signed [W-1:0]   y_i [4],
  input  logic [3:0]            neg_i,
  input  logic signed [W-1:0]   add_i,
  output logic signed [2*W-1:0] prod0_o,
  output logic signed [W-1:0]   val_o,
  output logic                  sat_o
);

  localparam int AW = ((2 * W > W + F) ? 2 * W : W + F) + 3;
  localparam logic signed [AW-1:0] VMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] VMIN = ~VMAX;

  logic signed [2*W-1:0] prod_q [4];
  logic [3:0]            neg_q;
  logic signed [W-1:0]   add_q;
  logic signed [AW-1:0]  sum_d;
  logic signed [AW-1:0]  shr_d;
  logic signed [W-1:0]   val_d;
  logic                  sat_d;

  // Stage 1: multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= x_i[k] * y_i[k];
      end
      neg_q <= neg_i;
      add_q <= add_i;
    end
  end

  // Exact sum, rounding and clip
  always_comb begin
    sum_d = (AW'(add_q) <<< F) + (AW'(1) <<< (F - 1));
    for (int k = 0; k < 4; k++) begin
      sum_d = neg_q[k] ? sum_d - AW'(prod_q[k]) : sum_d + AW'(prod_q[k]);
    end
    shr_d = sum_d >>> F;
    sat_d = 1'b1;
    if (shr_d > VMAX) begin
      val_d = VMAX[W-1:0];
    end else if (shr_d < VMIN) begin
      val_d = VMIN[W-1:0];
    end else begin
      val_d = shr_d[W-1:0];
      sat_d = 1'b0;
    end
  end

  // Stage 2: lane result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o <= val_d;
      sat_o <= sat_d;
    end
  end

  assign prod0_o = prod_q[0];

endmodule

// ===== sv/qmu_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage
module qmu_isqrt #(
  parameter int W = 24
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*W+1:0]    rad_i,
  output logic [W:0]        root_o
);

  localparam int RW  = W + 1;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 3;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SW-1:0]  rad_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [SW-1:0]  rad_in;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[RMW-3:0], rad_in[SW-1:SW-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
        rad_q[k]  <= {rad_in[SW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== sv/qmu_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage
module qmu_div #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W+F:0]     num_i,
  input  logic [W:0]       den_i,
  output logic [W+F:0]     quot_o
);

  localparam int NW = W + F + 1;
  localparam int DW = W + 1;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rem_sh = {rem_in, nq_in[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = nq_q[NW-1];

endmodule

// ===== sv/quaternion_math_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   a_x a_y a_z a_w b_x b_y b_z b_w scalar      opcode
// m_axis    out  r_x r_y r_z r_w                             status
//
// One item per cycle sustained while no result waits on m_axis_tready; the pipeline
// depth is set by the bit-per-stage square root and divider chains.
// Reset clears the valid pipeline only; no clearing pass.
// The whole pipeline holds while a result waits on m_axis_tready; s_axis_tready
// follows that stall.
module quaternion_math_unit
  import qmu_pkg::*;
#(
  parameter int DATA_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // opcode
  input  logic [2:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // r_x, r_y, r_z, r_w
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = W + 1;
  localparam int SW  = 2 * RW;
  localparam int NW  = W + F + 1;
  localparam int DW  = W + 1;
  localparam int LAT = 2 + RW + NW + 1;
  localparam int OUT_TDW = ((4 * W + 7) / 8) * 8;
  localparam int PAW = 3 + 9 * W;
  localparam int PBW = 3 + 8 * W + 4;
  localparam int PCW = 5 * W + 9;
  localparam int PDW = 4 * W + 7;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [NW-1:0] HALF = NW'(1) << (W - 1);

  logic            adv;
  logic            s_acc;
  logic [LAT-1:0]  vld_q;

  // Handshake and valid pipeline
  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_acc         = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_acc};
    end
  end

  // Input beat unpack
  opcode_e             op_in;
  logic signed [W-1:0] a_in [4];
  logic signed [W-1:0] b_in [4];
  logic signed [W-1:0] s_in;

  assign op_in = opcode_e'(s_axis_tuser);
  assign s_in  = s_axis_tdata[8*W +: W];
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign a_in[i] = s_axis_tdata[W*i +: W];
    assign b_in[i] = s_axis_tdata[W*(4+i) +: W];
  end

  // First pass operand select per lane
  logic signed [W-1:0] x1 [4][4];
  logic signed [W-1:0] y1 [4][4];
  logic [3:0]          n1 [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      n1[l] = '0;
      for (int k = 0; k < 4; k++) begin
        x1[l][k] = '0;
        y1[l][k] = '0;
      end
      unique case (op_in)
        OP_MUL: begin
          for (int k = 0; k < 4; k++) begin
            x1[l][k] = a_in[MUL_A[k]];
            y1[l][k] = b_in[MUL_B[l][k]];
          end
          n1[l] = MUL_N[l];
        end
        OP_ROT: begin
          // twice the cross product of A.xyz and v
          if (l < 3) begin
            x1[l][0] = a_in[CRS_A[l]];
            y1[l][0] = b_in[CRS_B[l]];
            x1[l][1] = a_in[CRS_A[l]];
            y1[l][1] = b_in[CRS_B[l]];
            x1[l][2] = a_in[CRS_B[l]];
            y1[l][2] = b_in[CRS_A[l]];
            x1[l][3] = a_in[CRS_B[l]];
            y1[l][3] = b_in[CRS_A[l]];
            n1[l]    = 4'b1100;
          end
        end
        OP_SCL: begin
          x1[l][0] = a_in[l];
          y1[l][0] = s_in;
        end
        OP_NRM: begin
          x1[l][0] = a_in[l];
          y1[l][0] = a_in[l];
        end
        default: begin
        end
      endcase
    end
  end

  // First pass lanes
  logic signed [2*W-1:0] prod0 [4];
  logic signed [W-1:0]   v1 [4];
  logic [3:0]            sat1;

  for (genvar l = 0; l < 4; l++) begin : g_lane1
    qmu_lane #(.W(W), .F(F)) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .x_i     (x1[l]),
      .y_i     (y1[l]),
      .neg_i   (n1[l]),
      .add_i   ('0),
      .prod0_o (prod0[l]),
      .val_o   (v1[l]),
      .sat_o   (sat1[l])
    );
  end

  // Item fields alongside the first pass
  logic [PAW-1:0] pa_q;

  qmu_pipe #(.WIDTH(PAW), .DEPTH(2)) u_pipe_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({s_axis_tuser, s_axis_tdata[9*W-1:0]}),
    .q_o   (pa_q)
  );

  opcode_e             op2;
  logic signed [W-1:0] a2 [4];
  logic signed [W-1:0] b2 [4];
  logic signed [W-1:0] s2;

  assign op2 = opcode_e'(pa_q[9*W +: 3]);
  assign s2  = pa_q[8*W +: W];
  for (genvar i = 0; i < 4; i++) begin : g_unpack2
    assign a2[i] = pa_q[W*i +: W];
    assign b2[i] = pa_q[W*(4+i) +: W];
  end

  // Sum of squares for the length, held to 64 bits
  logic [SW-1:0] sq_sum;
  logic [SW-1:0] sq_clip;
  logic [SW-1:0] sq_q;

  always_comb begin
    sq_sum = '0;
    for (int l = 0; l < 4; l++) begin
      sq_sum = sq_sum + SW'($unsigned(prod0[l]));
    end
  end

  if (SW > 64) begin : g_clamp
    assign sq_clip = (|sq_sum[SW-1:64]) ? {{(SW-64){1'b0}}, {64{1'b1}}} : sq_sum;
  end else begin : g_noclamp
    assign sq_clip = sq_sum;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= sq_clip;
    end
  end

  // Second pass operands: v + w*t + cross(A.xyz, t)
  logic signed [W-1:0] x2 [3][4];
  logic signed [W-1:0] y2 [3][4];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      x2[l][0] = a2[3];
      y2[l][0] = v1[l];
      x2[l][1] = a2[CRS_A[l]];
      y2[l][1] = v1[CRS_B[l]];
      x2[l][2] = a2[CRS_B[l]];
      y2[l][2] = v1[CRS_A[l]];
      x2[l][3] = '0;
      y2[l][3] = '0;
    end
  end

  logic signed [W-1:0] v2 [3];
  logic [2:0]          sat2;

  for (genvar l = 0; l < 3; l++) begin : g_lane2
    qmu_lane #(.W(W), .F(F)) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .x_i     (x2[l]),
      .y_i     (y2[l]),
      .neg_i   (4'b0100),
      .add_i   (b2[l]),
      .prod0_o (),
      .val_o   (v2[l]),
      .sat_o   (sat2[l])
    );
  end

  // First pass results and A alongside the second pass
  logic [4*W-1:0] v1_p;
  logic [PBW-1:0] pb_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      v1_p[W*l +: W] = v1[l];
    end
  end

  qmu_pipe #(.WIDTH(PBW), .DEPTH(2)) u_pipe_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({op2, sat1, v1_p, pa_q[4*W-1:0]}),
    .q_o   (pb_q)
  );

  opcode_e             op4;
  logic signed [W-1:0] a4 [4];
  logic signed [W-1:0] v14 [4];
  logic [3:0]          sat14;

  assign op4   = opcode_e'(pb_q[8*W+4 +: 3]);
  assign sat14 = pb_q[8*W +: 4];
  for (genvar i = 0; i < 4; i++) begin : g_unpack4
    assign a4[i]  = pb_q[W*i +: W];
    assign v14[i] = pb_q[4*W + W*i +: W];
  end

  // Results of the multiply-based operations and of the conjugate
  logic [4*W-1:0] ev_p;
  logic [3:0]     es;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ev_p[W*l +: W] = '0;
      es[l]          = 1'b0;
      unique case (op4)
        OP_MUL, OP_SCL: begin
          ev_p[W*l +: W] = v14[l];
          es[l]          = sat14[l];
        end
        OP_ROT: begin
          if (l < 3) begin
            ev_p[W*l +: W] = v2[l];
            es[l]          = sat14[l] | sat2[l];
          end
        end
        OP_CNJ: begin
          if (l < 3) begin
            ev_p[W*l +: W] = (a4[l] == VMIN) ? VMAX : -a4[l];
            es[l]          = (a4[l] == VMIN);
          end else begin
            ev_p[W*l +: W] = a4[l];
          end
        end
        default: begin
        end
      endcase
    end
  end

  logic [PDW-1:0] pd_q;

  qmu_pipe #(.WIDTH(PDW), .DEPTH(RW + NW - 2)) u_pipe_d (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({op4, es, ev_p}),
    .q_o   (pd_q)
  );

  // Length of A
  logic [RW-1:0] root;

  qmu_isqrt #(.W(W)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sq_q),
    .root_o (root)
  );

  // Magnitudes and signs alongside the square root
  logic [4*W-1:0] amag_p;
  logic [3:0]     aneg;
  logic [PCW-1:0] pc_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      aneg[l]          = a2[l][W-1];
      amag_p[W*l +: W] = aneg[l] ? W'(-a2[l]) : W'(a2[l]);
    end
  end

  qmu_pipe #(.WIDTH(PCW), .DEPTH(RW)) u_pipe_c (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({op2, (s2 == '0), s2[W-1], aneg,
             (s2[W-1] ? W'(-s2) : W'(s2)), amag_p}),
    .q_o   (pc_q)
  );

  opcode_e        opc;
  logic [W-1:0]   smag_c;
  logic [3:0]     aneg_c;
  logic           sneg_c;
  logic           szero_c;
  logic [DW-1:0]  den;
  logic           err_c;
  logic [3:0]     dneg_c;
  logic [NW-1:0]  num [4];

  assign opc     = opcode_e'(pc_q[5*W+6 +: 3]);
  assign szero_c = pc_q[5*W+5];
  assign sneg_c  = pc_q[5*W+4];
  assign aneg_c  = pc_q[5*W +: 4];
  assign smag_c  = pc_q[4*W +: W];

  // Divisor: length for normalize, |scalar| for divide
  assign den   = (opc == OP_NRM) ? root : {1'b0, smag_c};
  assign err_c = ((opc == OP_NRM) && (root == '0)) || ((opc == OP_DIV) && szero_c);

  for (genvar l = 0; l < 4; l++) begin : g_div
    assign dneg_c[l] = aneg_c[l] ^ ((opc == OP_DIV) && sneg_c);
    // |a| << F plus half the divisor rounds to nearest
    assign num[l] = {1'b0, pc_q[W*l +: W], {F{1'b0}}} + NW'(den >> 1);
  end

  logic [NW-1:0] quot [4];

  for (genvar l = 0; l < 4; l++) begin : g_divu
    qmu_div #(.W(W), .F(F)) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num[l]),
      .den_i  (den),
      .quot_o (quot[l])
    );
  end

  logic [4:0] pe_q;

  qmu_pipe #(.WIDTH(5), .DEPTH(NW)) u_pipe_e (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({err_c, dneg_c}),
    .q_o   (pe_q)
  );

  // Merge: pick the unit per opcode, sign and clip quotients, form status
  opcode_e             opf;
  logic [3:0]          esf;
  logic [3:0]          negf;
  logic                errf;
  logic signed [W-1:0] rv [4];
  logic                big;
  logic                sat_any;
  logic [4*W-1:0]      res_d;
  status_e             st_d;
  logic [4*W-1:0]      res_q;
  status_e             st_q;

  assign opf  = opcode_e'(pd_q[4*W+4 +: 3]);
  assign esf  = pd_q[4*W +: 4];
  assign negf = pe_q[3:0];
  assign errf = pe_q[4];

  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < 4; l++) begin
      big = 1'b0;
      if (opf == OP_NRM || opf == OP_DIV) begin
        big = negf[l] ? (quot[l] > HALF) : (quot[l] >= HALF);
        if (big) begin
          rv[l] = negf[l] ? VMIN : VMAX;
        end else begin
          rv[l] = negf[l] ? -quot[l][W-1:0] : quot[l][W-1:0];
        end
      end else begin
        rv[l] = pd_q[W*l +: W];
        big   = esf[l];
      end
      sat_any = sat_any | big;
      res_d[W*l +: W] = errf ? '0 : rv[l];
    end
    if (errf) begin
      st_d = ST_ZERO;
    end else if (sat_any) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = OUT_TDW'(res_q);
  assign m_axis_tuser  = st_q;

endmodule

// ===== sv/qmu_checker.sv =====
`timescale 1ns / 1ps

module qmu_checker
  import qmu_pkg::*;
#(
  parameter int DATA_WIDTH = 24
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input logic [1:0]                          m_axis_tuser
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed under stall");

  // Input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (s_axis_tready == (!m_axis_tvalid || m_axis_tready)))
    else $error("input ready does not track output stall");

  // Only defined status codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == ST_OK || m_axis_tuser == ST_ZERO || m_axis_tuser == ST_SAT))
    else $error("undefined status code");

  // Zero divisor or zero length gives an all-zero result
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ZERO) |-> (m_axis_tdata == '0))
    else $error("error status with nonzero result");

endmodule

bind quaternion_math_unit qmu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qmu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/quaternion_math_unit_tb.sv =====
`timescale 1ns / 1ps

module quaternion_math_unit_tb;
  import qmu_pkg::*;

  localparam int DW = 24;
  localparam int FB = 16;
  localparam int IN_W = ((9*DW+7)/8)*8;
  localparam int OUT_W = ((4*DW+7)/8)*8;
  localparam int LATENCY = 2*DW + FB + 5;
  localparam int N_RANDOM = 850;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint VMAX = (64'sd1 <<< (DW-1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    opcode_e     op;
    logic [DW-1:0] a [4];
    logic [DW-1:0] b [4];
    logic [DW-1:0] s;
  } qitem_t;

  typedef struct {
    logic [DW-1:0] r [4];
    status_e       st;
  } qres_t;

  // Fixed-point quaternion arithmetic, computed in 128-bit to stay exact
  function automatic longint sx(logic [DW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clip(longint v, ref bit sat);
    if (v > VMAX) begin
      sat = 1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1;
      return VMIN;
    end
    return v;
  endfunction

  // sum of products, one rounding half up: floor((sum + half) / 2^FB)
  function automatic longint rnd(logic signed [127:0] acc);
    logic signed [127:0] t;
    t = acc + (128'sd1 <<< (FB-1));
    return longint'(t >>> FB);
  endfunction

  function automatic longint div_rnd(longint x, longint d);
    logic [127:0] n, m, q;
    n = (x < 0) ? -x : x;
    m = (d < 0) ? -d : d;
    q = ((n << FB) + m / 2) / m;
    return ((x < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt(logic [127:0] n);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'd1 << 50;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic qres_t predict_quat(qitem_t it);
    qres_t res;
    longint a [4], b [4], r [4], t [3], s, len;
    logic signed [127:0] acc;
    logic [127:0] sq;
    bit sat, err;
    sat = 0;
    err = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = sx(it.a[i]);
      b[i] = sx(it.b[i]);
      r[i] = 0;
    end
    s = sx(it.s);
    case (it.op)
      OP_MUL: begin
        r[3] = clip(rnd(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]), sat);
        r[0] = clip(rnd(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]), sat);
        r[1] = clip(rnd(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0]), sat);
        r[2] = clip(rnd(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3]), sat);
      end
      OP_CNJ: begin
        for (int i = 0; i < 3; i++) r[i] = clip(-a[i], sat);
        r[3] = a[3];
      end
      OP_NRM: begin
        sq = 0;
        // square taken signed before it joins the unsigned sum
        for (int i = 0; i < 4; i++) sq += 128'(a[i] * a[i]);
        len = isqrt(sq);
        if (len == 0) err = 1;
        else for (int i = 0; i < 4; i++) r[i] = clip(div_rnd(a[i], len), sat);
      end
      OP_ROT: begin
        t[0] = clip(rnd(2*(128'(a[1]*b[2]) - a[2]*b[1])), sat);
        t[1] = clip(rnd(2*(128'(a[2]*b[0]) - a[0]*b[2])), sat);
        t[2] = clip(rnd(2*(128'(a[0]*b[1]) - a[1]*b[0])), sat);
        for (int i = 0; i < 3; i++) begin
          acc = (128'(b[i]) <<< FB) + a[3]*t[i];
          case (i)
            0: acc += a[1]*t[2] - a[2]*t[1];
            1: acc += a[2]*t[0] - a[0]*t[2];
            default: acc += a[0]*t[1] - a[1]*t[0];
          endcase
          r[i] = clip(rnd(acc), sat);
        end
      end
      OP_SCL: for (int i = 0; i < 4; i++) r[i] = clip(rnd(a[i]*s), sat);
      OP_DIV: begin
        if (s == 0) err = 1;
        else for (int i = 0; i < 4; i++) r[i] = clip(div_rnd(a[i], s), sat);
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = err ? '0 : r[i][DW-1:0];
    res.st = err ? ST_ZERO : (sat ? ST_SAT : ST_OK);
    return res;
  endfunction

  // Expected-result queue with in-order compare
  class quat_scoreboard;
    qres_t  pending [$];
    int     n_bad;
    int     n_seen;

    function void note_input(qitem_t it);
      pending.push_back(predict_quat(it));
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic [1:0] u);
      qres_t e;
      bit ok;
      n_seen++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %h status %0d", d, u);
        return;
      end
      e = pending.pop_front();
      ok = (u == e.st);
      for (int i = 0; i < 4; i++) ok &= (d[i*DW +: DW] == e.r[i]);
      if (!ok) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch #%0d exp %h %h %h %h st %0d got %h %h %h %h st %0d",
                   n_seen, e.r[0], e.r[1], e.r[2], e.r[3], e.st,
                   d[0 +: DW], d[DW +: DW], d[2*DW +: DW], d[3*DW +: DW], u);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  quaternion_math_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  quat_scoreboard sb = new();
  longint cycles = 0;
  bit hold_sink = 0;
  int n_sent = 0;
  int op_seen [8];

  // Watchdog and sampling at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("quaternion_math_unit_tb NOT OK");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver stall pattern, with optional long hold-off
  always @(negedge clk_i) begin
    if (hold_sink) m_axis_tready <= 0;
    else if ((cycles / 200) % 3 == 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [DW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return VMAX[DW-1:0];
      1: return VMIN[DW-1:0];
      2: return '0;
      3, 4: return DW'($urandom_range(0, 1 << (FB+1))) - DW'(1 << FB);
      5: return {DW{1'b1}};
      default: return DW'($urandom);
    endcase
  endfunction

  // Drive one beat and wait until it is taken
  task automatic send_item(qitem_t it);
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.op;
    for (int i = 0; i < 4; i++) begin
      s_axis_tdata[i*DW +: DW] <= it.a[i];
      s_axis_tdata[(4+i)*DW +: DW] <= it.b[i];
    end
    s_axis_tdata[8*DW +: DW] <= it.s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
    n_sent++;
    op_seen[it.op]++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  function automatic qitem_t mk(opcode_e op, longint a0, longint a1, longint a2,
                                longint a3, longint b0, longint b1, longint b2,
                                longint b3, longint s);
    qitem_t it;
    it.op = op;
    it.a = '{a0[DW-1:0], a1[DW-1:0], a2[DW-1:0], a3[DW-1:0]};
    it.b = '{b0[DW-1:0], b1[DW-1:0], b2[DW-1:0], b3[DW-1:0]};
    it.s = s[DW-1:0];
    return it;
  endfunction

  localparam longint ONE = 1 << FB;

  initial begin
    qitem_t it;
    int burst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: every operation, extremes, zero divisor and length, saturation
    send_item(mk(OP_MUL, 0, 0, 0, ONE, ONE, 2*ONE, 3*ONE, 4*ONE, 0));
    send_item(mk(OP_MUL, VMAX, VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, VMIN, 0));
    send_item(mk(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0));
    send_item(mk(OP_CNJ, VMIN, VMAX, -1, VMIN, 0, 0, 0, 0, 0));
    send_item(mk(OP_CNJ, ONE, -ONE, 5, 7, 0, 0, 0, 0, 0));
    send_item(mk(OP_NRM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_NRM, 3*ONE, 4*ONE, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_NRM, VMIN, VMIN, VMIN, VMIN, 0, 0, 0, 0, 0));
    send_item(mk(OP_NRM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(mk(OP_NRM, 1, 1, 1, 1, 0, 0, 0, 0, 0));
    send_item(mk(OP_ROT, 0, 0, 46341, 46341, ONE, 0, 0, 0, 0));
    send_item(mk(OP_ROT, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, 0, 0));
    send_item(mk(OP_ROT, 0, 0, 0, ONE, VMIN, VMAX, 0, VMAX, 0));
    send_item(mk(OP_SCL, ONE, -ONE, VMAX, VMIN, 0, 0, 0, 0, VMAX));
    send_item(mk(OP_SCL, 1, -1, 3, VMIN, 0, 0, 0, 0, ONE/2));
    send_item(mk(OP_SCL, VMIN, 0, 0, 0, 0, 0, 0, 0, VMIN));
    send_item(mk(OP_DIV, ONE, 2*ONE, 3, VMIN, 0, 0, 0, 0, 0));
    send_item(mk(OP_DIV, ONE, 3, VMAX, VMIN, 0, 0, 0, 0, 3*ONE));
    send_item(mk(OP_DIV, VMAX, VMIN, 1, -1, 0, 0, 0, 0, 1));
    send_item(mk(OP_DIV, VMIN, 5, -5, 3, 0, 0, 0, 0, VMIN));
    send_item(mk(OP_DIV, 7, -7, 1, -1, 0, 0, 0, 0, -2));
    begin
      qitem_t u;
      u = mk(OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      u.op = opcode_e'(3'd6);
      send_item(u);
      u.op = opcode_e'(3'd7);
      u.a[0] = VMAX[DW-1:0];
      send_item(u);
    end

    // Sender pauses until the pipeline is empty
    drain();

    // Long receiver hold-off while items keep coming
    fork
      begin
        hold_sink = 1;
        repeat (LATENCY * 3) @(negedge clk_i);
        hold_sink = 0;
      end
    join_none

    // Random bursts with random gaps
    while (n_sent < N_RANDOM + 23) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        it.op = opcode_e'($urandom_range(0, 15) == 0 ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5));
        for (int i = 0; i < 4; i++) begin
          it.a[i] = rand_comp();
          it.b[i] = rand_comp();
        end
        it.s = rand_comp();
        send_item(it);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end

    drain();
    $display("sent %0d beats: mul %0d cnj %0d nrm %0d rot %0d scl %0d div %0d other %0d",
             n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5], op_seen[6] + op_seen[7]);
    $display("checked %0d results, %0d mismatches", sb.n_seen, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending.size() == 0)
      $display("quaternion_math_unit_tb OK");
    else
      $display("quaternion_math_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
sv/qmu_pkg.sv
sv/qmu_pipe.sv
sv/qmu_lane.sv
sv/qmu_isqrt.sv
sv/qmu_div.sv
sv/quaternion_math_unit.sv
sv/qmu_checker.sv
tb/quaternion_math_unit_tb.sv
